// ===== src/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, token and result codes, stack sizes and the operator priority
// table for the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

	// Stack sizes
	localparam int STACK_DEPTH = 32;
	localparam int FUNC_DEPTH  = 16;
	localparam int OP_ADDR_W   = $clog2(STACK_DEPTH);
	localparam int OP_CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int FN_ADDR_W   = $clog2(FUNC_DEPTH);
	localparam int FN_CNT_W    = $clog2(FUNC_DEPTH + 1);

	// Field widths
	localparam int KIND_W  = 4;
	localparam int OP_W    = 5;
	localparam int FUNC_W  = 3;
	localparam int VALUE_W = 64;
	localparam int OKIND_W = 3;
	localparam int ERR_W   = 2;
	localparam int NEST_W  = 6;
	localparam int PRIO_W  = 3;

	// Input token kinds
	localparam logic [KIND_W-1:0] KIND_VAR    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_CONST  = 4'd1;
	localparam logic [KIND_W-1:0] KIND_BINOP  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_PREFIX = 4'd3;
	localparam logic [KIND_W-1:0] KIND_OPEN   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_FUNC   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_END    = 4'd8;

	// Result kinds
	localparam logic [OKIND_W-1:0] OUT_LOAD_VAR   = 3'd0;
	localparam logic [OKIND_W-1:0] OUT_LOAD_CONST = 3'd1;
	localparam logic [OKIND_W-1:0] OUT_OPERATION  = 3'd2;
	localparam logic [OKIND_W-1:0] OUT_CALL       = 3'd3;
	localparam logic [OKIND_W-1:0] OUT_END        = 3'd4;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OP_FULL = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FUNC    = 2'd2;
	localparam logic [ERR_W-1:0] ERR_NEST    = 2'd3;

	// Stack entry codes beyond the operators
	localparam logic [OP_W-1:0] OP_MAX    = 5'd19;
	localparam logic [OP_W-1:0] OPEN_MARK = 5'd20;
	localparam logic [OP_W-1:0] FUNC_MARK = 5'd21;

	localparam logic [NEST_W-1:0] NEST_MAX = 6'd63;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_RD,
		ST_CHK,
		ST_FRD,
		ST_FEMIT,
		ST_PUSH,
		ST_CNEST,
		ST_END,
		ST_DONE
	} state_t;

	// What the pop loop is working for
	typedef enum logic [2:0] {
		MODE_BINOP,
		MODE_CLOSE,
		MODE_CLOSE_FN,
		MODE_COMMA,
		MODE_FLUSH
	} mode_t;

	typedef struct packed {
		logic [OKIND_W-1:0] kind;
		logic [OP_W-1:0]    op;
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value;
		logic [ERR_W-1:0]   err;
	} result_t;

	typedef struct packed {
		logic    v;
		result_t r;
	} emit_t;

	typedef struct packed {
		logic                 we;
		logic [OP_ADDR_W-1:0] waddr;
		logic [OP_W-1:0]      wdata;
		logic                 re;
		logic [OP_ADDR_W-1:0] raddr;
	} op_ram_req_t;

	typedef struct packed {
		logic                 we;
		logic [FN_ADDR_W-1:0] waddr;
		logic [FUNC_W-1:0]    wdata;
		logic                 re;
		logic [FN_ADDR_W-1:0] raddr;
	} fn_ram_req_t;

	// Operator priority; function marker binds tightest, open paren lowest
	function automatic logic [PRIO_W-1:0] op_prio(input logic [OP_W-1:0] e);
		logic [PRIO_W-1:0] p;
		begin
			case (e)
				5'd0:  p = 3'd0;
				5'd1,  5'd2: p = 3'd1;
				5'd3,  5'd4,  5'd5: p = 3'd2;
				5'd6,  5'd7: p = 3'd3;
				5'd8,  5'd9,  5'd10: p = 3'd4;
				5'd11: p = 3'd5;
				5'd12, 5'd13, 5'd14, 5'd15,
				5'd16, 5'd17, 5'd18, 5'd19: p = 3'd6;
				FUNC_MARK: p = 3'd7;
				default: p = 3'd0;
			endcase
			return p;
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/i2p_ram.sv =====
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/i2p_out.sv =====
// ----------------------------------------------------------------------------
// i2p_out
// Result buffer: one pending word plus the output register. A word is held
// back until the next one arrives or the token finishes, so the final word of
// a token can carry its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_out
	import i2p_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire emit_t   emit,
	input  wire logic    fin,
	output logic         slot_ok,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      res,
	output logic         res_last
);

	logic    pend_v_q;
	result_t pend_q;
	logic    out_valid_q;
	result_t out_q;
	logic    last_q;
	logic    out_free;

	// output register empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	assign slot_ok  = !pend_v_q || out_free;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (emit.v && slot_ok) begin
			pend_v_q <= 1'b1;
			if (pend_v_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end else if (fin && pend_v_q && out_free) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (emit.v && slot_ok) begin
			pend_q <= emit.r;
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
		end else if (fin && pend_v_q && out_free) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;
	assign res_last  = last_q;

endmodule

`default_nettype wire

// ===== src/i2p_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2p_ctrl
// Token sequencer: keeps the stack counters and the nesting level, walks the
// operator stack memory one entry at a time and issues result words.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_ctrl
	import i2p_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [KIND_W-1:0]  token_kind,
	input  wire logic [OP_W-1:0]    op_code,
	input  wire logic [FUNC_W-1:0]  func_index,
	input  wire logic [VALUE_W-1:0] operand_value,
	output op_ram_req_t             op_req,
	input  wire logic [OP_W-1:0]    op_rdata,
	output fn_ram_req_t             fn_req,
	input  wire logic [FUNC_W-1:0]  fn_rdata,
	output emit_t                   emit,
	output logic                    fin,
	input  wire logic               slot_ok
);

	state_t               state_q, state_d;
	mode_t                mode_q, mode_d;
	logic [KIND_W-1:0]    kind_q;
	logic [OP_W-1:0]      code_q;
	logic [FUNC_W-1:0]    func_q;
	logic [VALUE_W-1:0]   value_q;
	logic [OP_CNT_W-1:0]  op_cnt_q, op_cnt_d;
	logic [FN_CNT_W-1:0]  fn_cnt_q, fn_cnt_d;
	logic [NEST_W-1:0]    nest_q, nest_d;
	logic [OP_CNT_W-1:0]  op_top;
	logic [FN_CNT_W-1:0]  fn_top;
	logic [NEST_W-1:0]    nest_dec;
	logic                 op_full;
	logic                 fn_full;
	logic                 top_is_open;
	logic                 top_is_func;
	state_t               after_pop;

	assign op_top      = op_cnt_q - OP_CNT_W'(1);
	assign fn_top      = fn_cnt_q - FN_CNT_W'(1);
	assign nest_dec    = (nest_q != '0) ? nest_q - NEST_W'(1) : '0;
	assign op_full     = (op_cnt_q == OP_CNT_W'(STACK_DEPTH));
	assign fn_full     = (fn_cnt_q == FN_CNT_W'(FUNC_DEPTH));
	assign top_is_open = (op_rdata == OPEN_MARK);
	assign top_is_func = (op_rdata == FUNC_MARK);
	assign after_pop   = (mode_q == MODE_CLOSE_FN) ? ST_CNEST : ST_RD;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_BINOP;
			op_cnt_q <= '0;
			fn_cnt_q <= '0;
			nest_q   <= NEST_W'(1);
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			op_cnt_q <= op_cnt_d;
			fn_cnt_q <= fn_cnt_d;
			nest_q   <= nest_d;
		end
	end

	// token capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= token_kind;
			code_q  <= op_code;
			func_q  <= func_index;
			value_q <= operand_value;
		end
	end

	// next state, memory requests and result words
	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		op_cnt_d = op_cnt_q;
		fn_cnt_d = fn_cnt_q;
		nest_d   = nest_q;
		in_ready = 1'b0;
		fin      = 1'b0;
		op_req   = '0;
		fn_req   = '0;
		emit     = '0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DISP;
				end
			end

			ST_DISP: begin
				case (kind_q)
					KIND_VAR, KIND_CONST: begin
						if (slot_ok) begin
							emit.v       = 1'b1;
							emit.r.kind  = (kind_q == KIND_VAR) ? OUT_LOAD_VAR : OUT_LOAD_CONST;
							emit.r.value = value_q;
							state_d      = ST_DONE;
						end
					end
					KIND_BINOP: begin
						mode_d  = MODE_BINOP;
						state_d = (code_q > OP_MAX) ? ST_DONE : ST_RD;
					end
					KIND_PREFIX: begin
						state_d = (code_q > OP_MAX) ? ST_DONE : ST_PUSH;
					end
					KIND_OPEN: begin
						if (nest_q >= NEST_MAX) begin
							if (slot_ok) begin
								emit.v      = 1'b1;
								emit.r.kind = OUT_END;
								emit.r.err  = ERR_NEST;
								op_cnt_d    = '0;
								fn_cnt_d    = '0;
								nest_d      = NEST_W'(1);
								state_d     = ST_DONE;
							end
						end else begin
							state_d = ST_PUSH;
						end
					end
					KIND_CLOSE: begin
						mode_d  = MODE_CLOSE;
						state_d = ST_RD;
					end
					KIND_COMMA: begin
						mode_d  = MODE_COMMA;
						state_d = ST_RD;
					end
					KIND_FUNC: begin
						state_d = ST_PUSH;
					end
					KIND_END: begin
						if (nest_q != NEST_W'(1)) begin
							if (slot_ok) begin
								emit.v      = 1'b1;
								emit.r.kind = OUT_END;
								emit.r.err  = ERR_NEST;
								op_cnt_d    = '0;
								fn_cnt_d    = '0;
								nest_d      = NEST_W'(1);
								state_d     = ST_DONE;
							end
						end else begin
							mode_d  = MODE_FLUSH;
							state_d = ST_RD;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end

			// fetch the top entry, or leave the loop on an empty stack
			ST_RD: begin
				if (op_cnt_q == '0) begin
					case (mode_q)
						MODE_BINOP:    state_d = ST_PUSH;
						MODE_CLOSE:    state_d = ST_CNEST;
						MODE_CLOSE_FN: state_d = ST_CNEST;
						MODE_COMMA:    state_d = ST_DONE;
						MODE_FLUSH:    state_d = ST_END;
						default:       state_d = ST_DONE;
					endcase
				end else begin
					op_req.re    = 1'b1;
					op_req.raddr = op_top[OP_ADDR_W-1:0];
					state_d      = ST_CHK;
				end
			end

			// decide on the top entry: stop, or pop it
			ST_CHK: begin
				if ((mode_q == MODE_BINOP) &&
					(top_is_open || (op_prio(op_rdata) < op_prio(code_q)))) begin
					state_d = ST_PUSH;
				end else if ((mode_q == MODE_CLOSE) && top_is_open) begin
					op_cnt_d = op_top;
					mode_d   = MODE_CLOSE_FN;
					state_d  = ST_RD;
				end else if ((mode_q == MODE_COMMA) && top_is_open) begin
					state_d = ST_DONE;
				end else if ((mode_q == MODE_CLOSE_FN) && !top_is_func) begin
					state_d = ST_CNEST;
				end else if (top_is_func) begin
					if (fn_cnt_q == '0) begin
						if (slot_ok) begin
							emit.v      = 1'b1;
							emit.r.kind = OUT_END;
							emit.r.err  = ERR_FUNC;
							op_cnt_d    = '0;
							fn_cnt_d    = '0;
							nest_d      = NEST_W'(1);
							state_d     = ST_DONE;
						end
					end else begin
						op_cnt_d = op_top;
						state_d  = ST_FRD;
					end
				end else if (op_rdata < OPEN_MARK) begin
					if (slot_ok) begin
						emit.v      = 1'b1;
						emit.r.kind = OUT_OPERATION;
						emit.r.op   = op_rdata;
						op_cnt_d    = op_top;
						state_d     = after_pop;
					end
				end else begin
					// parenthesis dropped silently
					op_cnt_d = op_top;
					state_d  = after_pop;
				end
			end

			ST_FRD: begin
				fn_req.re    = 1'b1;
				fn_req.raddr = fn_top[FN_ADDR_W-1:0];
				fn_cnt_d     = fn_top;
				state_d      = ST_FEMIT;
			end

			ST_FEMIT: begin
				if (slot_ok) begin
					emit.v      = 1'b1;
					emit.r.kind = OUT_CALL;
					emit.r.func = fn_rdata;
					state_d     = after_pop;
				end
			end

			ST_CNEST: begin
				nest_d = nest_dec;
				if (nest_dec == '0) begin
					mode_d  = MODE_FLUSH;
					state_d = ST_RD;
				end else begin
					state_d = ST_DONE;
				end
			end

			ST_END: begin
				if (slot_ok) begin
					emit.v      = 1'b1;
					emit.r.kind = OUT_END;
					emit.r.err  = ERR_NONE;
					op_cnt_d    = '0;
					fn_cnt_d    = '0;
					nest_d      = NEST_W'(1);
					state_d     = ST_DONE;
				end
			end

			ST_PUSH: begin
				if ((kind_q == KIND_FUNC) && fn_full) begin
					if (slot_ok) begin
						emit.v      = 1'b1;
						emit.r.kind = OUT_END;
						emit.r.err  = ERR_FUNC;
						op_cnt_d    = '0;
						fn_cnt_d    = '0;
						nest_d      = NEST_W'(1);
						state_d     = ST_DONE;
					end
				end else if (op_full) begin
					if (slot_ok) begin
						emit.v      = 1'b1;
						emit.r.kind = OUT_END;
						emit.r.err  = ERR_OP_FULL;
						op_cnt_d    = '0;
						fn_cnt_d    = '0;
						nest_d      = NEST_W'(1);
						state_d     = ST_DONE;
					end
				end else begin
					op_req.we    = 1'b1;
					op_req.waddr = op_cnt_q[OP_ADDR_W-1:0];
					op_cnt_d     = op_cnt_q + OP_CNT_W'(1);
					case (kind_q)
						KIND_OPEN: begin
							op_req.wdata = OPEN_MARK;
							nest_d       = nest_q + NEST_W'(1);
						end
						KIND_FUNC: begin
							op_req.wdata = FUNC_MARK;
							fn_req.we    = 1'b1;
							fn_req.waddr = fn_cnt_q[FN_ADDR_W-1:0];
							fn_req.wdata = func_q;
							fn_cnt_d     = fn_cnt_q + FN_CNT_W'(1);
						end
						default: begin
							op_req.wdata = code_q;
						end
					endcase
					state_d = ST_DONE;
				end
			end

			// release the held word with its last flag
			ST_DONE: begin
				fin = 1'b1;
				if (slot_ok) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter_core.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter from lexed tokens to postfix operation words.
// Tokens are taken one at a time: the next is accepted only once the sequencer
//   is back in idle. A load token's word goes to the pending slot and reaches
//   the output register when its token finishes. Each stack entry examined
//   takes a read and a decide step, and a popped function marker also takes an
//   index read; a stalled output holds the sequencer.
// Reset: stack counts clear, nesting level goes to one, output is empty; the
//   stack memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_core
	import i2p_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [KIND_W-1:0]  token_kind,
	input  wire logic [OP_W-1:0]    op_code,
	input  wire logic [FUNC_W-1:0]  func_index,
	input  wire logic [VALUE_W-1:0] operand_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [OKIND_W-1:0]      out_kind,
	output logic [OP_W-1:0]         out_op,
	output logic [FUNC_W-1:0]       out_func,
	output logic [VALUE_W-1:0]      out_value,
	output logic                    last,
	output logic [ERR_W-1:0]        error
);

	op_ram_req_t          op_req;
	fn_ram_req_t          fn_req;
	logic [OP_W-1:0]      op_rdata;
	logic [FUNC_W-1:0]    fn_rdata;
	emit_t                emit;
	logic                 fin;
	logic                 slot_ok;
	result_t              res;

	// operator stack
	i2p_ram #(
		.WIDTH (OP_W),
		.DEPTH (STACK_DEPTH)
	) u_op_ram (
		.clk   (clk),
		.we    (op_req.we),
		.waddr (op_req.waddr),
		.wdata (op_req.wdata),
		.re    (op_req.re),
		.raddr (op_req.raddr),
		.rdata (op_rdata)
	);

	// function index stack
	i2p_ram #(
		.WIDTH (FUNC_W),
		.DEPTH (FUNC_DEPTH)
	) u_fn_ram (
		.clk   (clk),
		.we    (fn_req.we),
		.waddr (fn_req.waddr),
		.wdata (fn_req.wdata),
		.re    (fn_req.re),
		.raddr (fn_req.raddr),
		.rdata (fn_rdata)
	);

	// sequencer
	i2p_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token_kind    (token_kind),
		.op_code       (op_code),
		.func_index    (func_index),
		.operand_value (operand_value),
		.op_req        (op_req),
		.op_rdata      (op_rdata),
		.fn_req        (fn_req),
		.fn_rdata      (fn_rdata),
		.emit          (emit),
		.fin           (fin),
		.slot_ok       (slot_ok)
	);

	// result buffer and output register
	i2p_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.fin       (fin),
		.slot_ok   (slot_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res),
		.res_last  (last)
	);

	assign out_kind  = res.kind;
	assign out_op    = res.op;
	assign out_func  = res.func;
	assign out_value = res.value;
	assign error     = res.err;

endmodule

`default_nettype wire
